// ===== hdl/bpq_pkg.sv =====
package bpq_pkg;

	// Queue geometry
	localparam int QUEUE_DEPTH = 16;
	localparam int PRIO_W      = 8;
	localparam int HANDLE_W    = 32;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Capacity register
	localparam int CAP_W = 5;
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
	localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// Configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-1:0] CAP_ADDR = 3'd0;

	// Result fields
	localparam int COUNT_OUT_W = 5;

	// Stream payload widths, rounded up to whole bytes
	localparam int S_TDATA_W = ((HANDLE_W + PRIO_W + 7) / 8) * 8;
	localparam int M_TDATA_W = ((HANDLE_W + 1 + COUNT_OUT_W + 1 + 7) / 8) * 8;
	localparam int M_PACK_W  = HANDLE_W + 1 + COUNT_OUT_W + 1;

	typedef enum logic {
		REQ_ADD  = 1'b0,
		REQ_TAKE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// Per-cycle command broadcast to every cell
	typedef struct packed {
		logic add;
		logic take;
	} cell_ctrl_t;

endpackage

// ===== hdl/bpq_cell.sv =====
module bpq_cell (
	input  logic                          clk,
	input  bpq_pkg::cell_ctrl_t           ctrl,
	input  logic                          occ,
	input  logic [bpq_pkg::HANDLE_W-1:0]  new_handle,
	input  logic [bpq_pkg::PRIO_W-1:0]    new_prio,
	input  logic                          prev_keep,
	input  logic [bpq_pkg::HANDLE_W-1:0]  prev_handle,
	input  logic [bpq_pkg::PRIO_W-1:0]    prev_prio,
	input  logic [bpq_pkg::HANDLE_W-1:0]  next_handle,
	input  logic [bpq_pkg::PRIO_W-1:0]    next_prio,
	output logic                          keep,
	output logic [bpq_pkg::HANDLE_W-1:0]  handle,
	output logic [bpq_pkg::PRIO_W-1:0]    prio
);
	import bpq_pkg::*;

	logic [HANDLE_W-1:0] handle_q;
	logic [PRIO_W-1:0]   prio_q;

	// Hold the entry when it ranks at or above the new one
	assign keep = occ && (prio_q >= new_prio);

	// Insert, shift toward the tail on add, or shift toward the head on take
	always_ff @(posedge clk) begin
		if (ctrl.add && !keep) begin
			if (prev_keep) begin
				handle_q <= new_handle;
				prio_q   <= new_prio;
			end else begin
				handle_q <= prev_handle;
				prio_q   <= prev_prio;
			end
		end else if (ctrl.take) begin
			handle_q <= next_handle;
			prio_q   <= next_prio;
		end
	end

	assign handle = handle_q;
	assign prio   = prio_q;

endmodule

// ===== hdl/bpq_apb.sv =====
module bpq_apb (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bpq_pkg::APB_AW-1:0]  paddr,
	input  logic [bpq_pkg::APB_DW-1:0]  pwdata,
	output logic [bpq_pkg::APB_DW-1:0]  prdata,
	output logic                        pready,
	output logic [bpq_pkg::CAP_W-1:0]   cap
);
	import bpq_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic             wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready && (paddr == CAP_ADDR);

	// Capture the capacity limit on a write transfer to CAP_ADDR
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (wr_en) begin
			cap_q <= pwdata[CAP_W-1:0];
		end
	end

	// Read back the register, zero elsewhere
	always_comb begin
		prdata = '0;
		if (paddr == CAP_ADDR) begin
			prdata = APB_DW'(cap_q);
		end
	end

	assign cap = cap_q;

endmodule

// ===== hdl/bounded_priority_queue_unit.sv =====
// Output: each result is registered and appears in the cycle after its request is accepted.
// Throughput: one add or take per cycle while m_tready is high. Every cell of
// the chain compares, inserts or shifts in the same cycle. A result held by a
// low m_tready holds off the next request until that result is transferred.
// Reset: clears the entry count and the output valid flag and sets the capacity
// limit to 16; cell contents are not cleared and are read only below the count.
module bounded_priority_queue_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	// s_tdata: work_handle, work_priority (from bit 0 up)
	input  logic [bpq_pkg::S_TDATA_W-1:0]  s_tdata,
	// s_tuser: req_type
	input  logic                           s_tuser,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// m_tdata: taken_handle, taken_valid, entry_count, queue_empty, zero pad
	output logic [bpq_pkg::M_TDATA_W-1:0]  m_tdata,
	// m_tuser: status_code
	output logic [1:0]                     m_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [bpq_pkg::APB_AW-1:0]     paddr,
	input  logic [bpq_pkg::APB_DW-1:0]     pwdata,
	output logic [bpq_pkg::APB_DW-1:0]     prdata,
	output logic                           pready
);
	import bpq_pkg::*;

	logic [CAP_W-1:0]    cap;
	logic [CNT_W-1:0]    count_q;
	logic [CNT_W-1:0]    count_d;
	logic                in_xfer;
	req_t                req;
	logic [HANDLE_W-1:0] in_handle;
	logic [PRIO_W-1:0]   in_prio;
	logic                full;
	logic                empty;
	cell_ctrl_t          ctrl;

	logic [HANDLE_W-1:0] cell_handle [QUEUE_DEPTH];
	logic [PRIO_W-1:0]   cell_prio   [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] cell_keep;
	logic [QUEUE_DEPTH-1:0] cell_occ;

	logic                m_tvalid_q;
	status_t             status_q;
	logic [HANDLE_W-1:0] taken_q;
	logic                taken_valid_q;
	logic [COUNT_OUT_W-1:0] count_out_q;
	logic                empty_q;

	bpq_apb u_apb (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cap     (cap)
	);

	// Unpack the request
	assign req       = req_t'(s_tuser);
	assign in_handle = s_tdata[HANDLE_W-1:0];
	assign in_prio   = s_tdata[HANDLE_W +: PRIO_W];

	// Take a new request whenever the output register is free or draining
	assign s_tready = !m_tvalid_q || m_tready;
	assign in_xfer  = s_tvalid && s_tready;

	assign full  = (CMP_W'(count_q) >= CMP_W'(cap)) || (count_q >= CNT_W'(QUEUE_DEPTH));
	assign empty = (count_q == '0);

	assign ctrl.add  = in_xfer && (req == REQ_ADD) && !full;
	assign ctrl.take = in_xfer && (req == REQ_TAKE) && !empty;

	// Advance the entry count
	always_comb begin
		count_d = count_q;
		if (ctrl.add) begin
			count_d = count_q + 1'b1;
		end else if (ctrl.take) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	// Chain of cells, head at index 0
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic                prev_keep;
		logic [HANDLE_W-1:0] prev_handle;
		logic [PRIO_W-1:0]   prev_prio;
		logic [HANDLE_W-1:0] next_handle;
		logic [PRIO_W-1:0]   next_prio;

		assign cell_occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign prev_keep   = 1'b1;
			assign prev_handle = '0;
			assign prev_prio   = '0;
		end else begin : g_body
			assign prev_keep   = cell_keep[i-1];
			assign prev_handle = cell_handle[i-1];
			assign prev_prio   = cell_prio[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_handle = '0;
			assign next_prio   = '0;
		end else begin : g_link
			assign next_handle = cell_handle[i+1];
			assign next_prio   = cell_prio[i+1];
		end

		bpq_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (cell_occ[i]),
			.new_handle  (in_handle),
			.new_prio    (in_prio),
			.prev_keep   (prev_keep),
			.prev_handle (prev_handle),
			.prev_prio   (prev_prio),
			.next_handle (next_handle),
			.next_prio   (next_prio),
			.keep        (cell_keep[i]),
			.handle      (cell_handle[i]),
			.prio        (cell_prio[i])
		);
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (in_xfer) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			if ((req == REQ_ADD) && full) begin
				status_q <= ST_FULL;
			end else if ((req == REQ_TAKE) && empty) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_DONE;
			end
			taken_q       <= ctrl.take ? cell_handle[0] : '0;
			taken_valid_q <= ctrl.take;
			count_out_q   <= COUNT_OUT_W'(count_d);
			empty_q       <= (count_d == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = M_TDATA_W'({empty_q, count_out_q, taken_valid_q, taken_q});

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("entry count above queue depth");

	a_empty_take: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && (req == REQ_TAKE) && empty) |=> (m_tuser == ST_EMPTY))
		else $error("take from empty queue not reported");

	a_take_count: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.take |=> (count_q == $past(count_q) - 1'b1))
		else $error("successful take did not drop the count");

	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (empty_q == (count_out_q == '0)))
		else $error("empty flag disagrees with entry count");
`endif

endmodule
